FILE: hdl/cshp_pkg.sv
package cshp_pkg;

  // host protocol bytes
  localparam logic [7:0] SYNC_BYTE    = 8'hF1;
  localparam logic [7:0] BINMODE_BYTE = 8'hE7;
  localparam logic [7:0] KEEP_HI_BYTE = 8'hDE;
  localparam logic [7:0] KEEP_LO_BYTE = 8'hAD;
  localparam logic [7:0] DEVINFO_BYTE = 8'h20;

  // command codes
  localparam logic [7:0] CMD_SEND_FRAME = 8'd0;
  localparam logic [7:0] CMD_TIME_SYNC  = 8'd1;
  localparam logic [7:0] CMD_BUTTONS    = 8'd2;
  localparam logic [7:0] CMD_ANALOG     = 8'd3;
  localparam logic [7:0] CMD_SET_OUT    = 8'd4;
  localparam logic [7:0] CMD_SET_BUS    = 8'd5;
  localparam logic [7:0] CMD_BUS_PARAM  = 8'd6;
  localparam logic [7:0] CMD_DEV_INFO   = 8'd7;
  localparam logic [7:0] CMD_SW_MODE    = 8'd8;
  localparam logic [7:0] CMD_KEEPALIVE  = 8'd9;
  localparam logic [7:0] CMD_SYS_TYPE   = 8'd10;
  localparam logic [7:0] CMD_ECHO_FRAME = 8'd11;
  localparam logic [7:0] CMD_BUS_COUNT  = 8'd12;
  localparam logic [7:0] CMD_EXT_BUSES  = 8'd13;
  localparam logic [7:0] CMD_SET_EXT    = 8'd14;

  // result kinds
  localparam logic [2:0] KIND_REPLY   = 3'd0;
  localparam logic [2:0] KIND_CONSOLE = 3'd1;
  localparam logic [2:0] KIND_SEND    = 3'd2;
  localparam logic [2:0] KIND_ECHO    = 3'd3;
  localparam logic [2:0] KIND_SAVED   = 3'd4;
  localparam logic [2:0] KIND_BINMODE = 3'd5;

  localparam logic [19:0] SPEED_MAX   = 20'd1000000;
  localparam logic [19:0] SPEED_RESET = 20'd500000;
  localparam logic [3:0]  DATA_MAX    = 4'd8;

  // work handed from parser to reply generator
  typedef enum logic [3:0] {
    J_CONSOLE, J_BINMODE, J_SEND, J_ECHO, J_SAVE, J_TIME, J_BUTTONS,
    J_ANALOG, J_BUSPARAM, J_DEVINFO, J_KEEPALIVE, J_BUSCOUNT, J_EXTBUS
  } job_op_t;

  typedef struct packed {
    job_op_t     op;
    logic [7:0]  byte_val;
    logic [31:0] word;
    logic [30:0] id;
    logic        ext;
    logic [1:0]  bus;
    logic [3:0]  len;
    logic [63:0] data;
    logic        en;
    logic [7:0]  systype;
  } job_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  byte_value;
    logic        last;
    logic [30:0] frame_id;
    logic        frame_extended;
    logic [1:0]  frame_bus;
    logic [3:0]  frame_length;
    logic [63:0] frame_data;
    logic        bus_enabled_out;
    logic [19:0] bus_speed_out;
    logic [7:0]  system_type_out;
  } res_t;

endpackage

FILE: hdl/cshp_queue.sv
module cshp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             not_empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign rdata     = mem_r[rd_ptr_r];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end
endmodule

FILE: hdl/cshp_front.sv
module cshp_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_fire,
  input  logic [7:0]     rx_byte,
  input  logic [31:0]    time_us,
  input  logic           log_pressed,
  input  logic           replay_pressed,
  output logic           push,
  output cshp_pkg::job_t job
);
  import cshp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_COMMAND, ST_FRAME_SEND, ST_SKIP_ONE, ST_SPEED, ST_SYSTYPE,
    ST_FRAME_ECHO, ST_EXT_BUSES
  } state_t;

  state_t      state_r, state_nxt;
  logic [4:0]  step_r, step_nxt;
  logic [31:0] id_r, id_nxt;
  logic        ext_r, ext_nxt;
  logic [1:0]  bus_r, bus_nxt;
  logic [3:0]  len_r, len_nxt;
  logic [7:0]  data_r [8];
  logic        data_we;
  logic [31:0] sw_r, sw_nxt;
  logic        en_r, en_nxt;
  logic [19:0] speed_r, speed_nxt;
  logic [7:0]  systype_r, systype_nxt;

  logic [31:0] full_word;
  logic [19:0] clamped;
  logic [4:0]  data_end;
  logic [63:0] masked;
  logic        is_frame;

  assign full_word = {rx_byte, sw_r[23:0]};
  assign clamped   = (full_word[19:0] > SPEED_MAX) ? SPEED_MAX : full_word[19:0];
  assign data_end  = {1'b0, len_r} + 5'd6;
  assign is_frame  = (state_r == ST_FRAME_SEND) || (state_r == ST_FRAME_ECHO);

  // frame data with bytes past the length cleared
  always_comb begin
    masked = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < len_r) begin
        masked[8*i +: 8] = data_r[i];
      end
    end
  end

  // parser next state and job emission
  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    id_nxt      = id_r;
    ext_nxt     = ext_r;
    bus_nxt     = bus_r;
    len_nxt     = len_r;
    sw_nxt      = sw_r;
    en_nxt      = en_r;
    speed_nxt   = speed_r;
    systype_nxt = systype_r;
    data_we     = 1'b0;
    push        = 1'b0;
    job         = '0;
    job.word    = time_us;
    job.byte_val = {6'b0, replay_pressed, log_pressed};
    if (in_fire) begin
      unique case (state_r)
        ST_IDLE: begin
          if (rx_byte == SYNC_BYTE) begin
            state_nxt = ST_COMMAND;
          end else if (rx_byte == BINMODE_BYTE) begin
            push   = 1'b1;
            job.op = J_BINMODE;
          end else begin
            push         = 1'b1;
            job.op       = J_CONSOLE;
            job.byte_val = rx_byte;
          end
        end
        ST_COMMAND: begin
          unique case (rx_byte)
            CMD_SEND_FRAME: begin state_nxt = ST_FRAME_SEND; step_nxt = '0; end
            CMD_TIME_SYNC: begin
              state_nxt = ST_SKIP_ONE; step_nxt = '0; push = 1'b1; job.op = J_TIME;
            end
            CMD_BUTTONS: begin state_nxt = ST_IDLE; push = 1'b1; job.op = J_BUTTONS; end
            CMD_ANALOG: begin state_nxt = ST_IDLE; push = 1'b1; job.op = J_ANALOG; end
            CMD_SET_OUT, CMD_SW_MODE: begin state_nxt = ST_SKIP_ONE; step_nxt = '0; end
            CMD_SET_BUS: begin state_nxt = ST_SPEED; step_nxt = '0; end
            CMD_BUS_PARAM: begin
              state_nxt = ST_IDLE; push = 1'b1; job.op = J_BUSPARAM;
              job.en = en_r; job.word = {12'b0, speed_r};
            end
            CMD_DEV_INFO: begin state_nxt = ST_IDLE; push = 1'b1; job.op = J_DEVINFO; end
            CMD_KEEPALIVE: begin state_nxt = ST_IDLE; push = 1'b1; job.op = J_KEEPALIVE; end
            CMD_SYS_TYPE: begin state_nxt = ST_SYSTYPE; step_nxt = '0; end
            CMD_ECHO_FRAME: begin state_nxt = ST_FRAME_ECHO; step_nxt = '0; end
            CMD_BUS_COUNT: begin state_nxt = ST_IDLE; push = 1'b1; job.op = J_BUSCOUNT; end
            CMD_EXT_BUSES: begin
              state_nxt = ST_IDLE; step_nxt = '0; push = 1'b1; job.op = J_EXTBUS;
            end
            CMD_SET_EXT: begin state_nxt = ST_EXT_BUSES; step_nxt = '0; end
            default: ;
          endcase
        end
        ST_FRAME_SEND, ST_FRAME_ECHO: begin
          step_nxt = step_r + 1'b1;
          if (step_r < 5'd4) begin
            unique case (step_r[1:0])
              2'd0: id_nxt = {24'b0, rx_byte};
              2'd1: id_nxt[15:8] = rx_byte;
              2'd2: id_nxt[23:16] = rx_byte;
              default: begin
                id_nxt[31:24] = {1'b0, rx_byte[6:0]};
                ext_nxt       = rx_byte[7];
              end
            endcase
          end else if (step_r == 5'd4) begin
            bus_nxt = (state_r == ST_FRAME_SEND) ? rx_byte[1:0] : {1'b0, rx_byte[0]};
          end else if (step_r == 5'd5) begin
            len_nxt = (rx_byte[3:0] > DATA_MAX) ? DATA_MAX : rx_byte[3:0];
          end else if (step_r < data_end) begin
            data_we = 1'b1;
          end else begin
            state_nxt = ST_IDLE;
            push      = 1'b1;
            job.op    = (state_r == ST_FRAME_SEND) ? J_SEND : J_ECHO;
            job.id    = id_r[30:0];
            job.ext   = ext_r;
            job.bus   = bus_r;
            job.len   = len_r;
            job.data  = masked;
          end
        end
        ST_SKIP_ONE: state_nxt = ST_IDLE;
        ST_SPEED: begin
          step_nxt = step_r + 1'b1;
          if (step_r < 5'd4) begin
            unique case (step_r[1:0])
              2'd0: sw_nxt = {24'b0, rx_byte};
              2'd1: sw_nxt[15:8] = rx_byte;
              2'd2: sw_nxt[23:16] = rx_byte;
              default: begin
                sw_nxt = full_word;
                if (full_word != '0) begin
                  en_nxt    = 1'b1;
                  speed_nxt = clamped;
                end else begin
                  en_nxt = 1'b0;
                end
              end
            endcase
          end else if (step_r >= 5'd7) begin
            state_nxt   = ST_IDLE;
            push        = 1'b1;
            job.op      = J_SAVE;
            job.en      = en_r;
            job.word    = {12'b0, speed_r};
            job.systype = systype_r;
          end
        end
        ST_SYSTYPE: begin
          systype_nxt = rx_byte;
          state_nxt   = ST_IDLE;
          push        = 1'b1;
          job.op      = J_SAVE;
          job.en      = en_r;
          job.word    = {12'b0, speed_r};
          job.systype = rx_byte;
        end
        ST_EXT_BUSES: begin
          step_nxt = step_r + 1'b1;
          if (step_r >= 5'd11) begin
            state_nxt = ST_IDLE;
          end
        end
        default: state_nxt = ST_IDLE;
      endcase
    end
  end

  // frame data bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        data_r[i] <= '0;
      end
    end else if (data_we && is_frame) begin
      data_r[3'(step_r - 5'd6)] <= rx_byte;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      step_r    <= '0;
      id_r      <= '0;
      ext_r     <= 1'b0;
      bus_r     <= '0;
      len_r     <= '0;
      sw_r      <= '0;
      en_r      <= 1'b0;
      speed_r   <= SPEED_RESET;
      systype_r <= '0;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      id_r      <= id_nxt;
      ext_r     <= ext_nxt;
      bus_r     <= bus_nxt;
      len_r     <= len_nxt;
      sw_r      <= sw_nxt;
      en_r      <= en_nxt;
      speed_r   <= speed_nxt;
      systype_r <= systype_nxt;
    end
  end
endmodule

FILE: hdl/cshp_back.sv
module cshp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  cshp_pkg::job_t job,
  input  logic           job_valid,
  output logic           pop,
  input  logic           listen_only,
  input  logic [15:0]    build_number,
  output logic           out_valid,
  input  logic           out_ready,
  output cshp_pkg::res_t res
);
  import cshp_pkg::*;

  logic [4:0] idx_r;
  logic       valid_r;
  res_t       res_r, res_nxt;
  logic [4:0] last_idx;
  logic [7:0] rbyte;
  logic       load;

  assign out_valid = valid_r;
  assign res       = res_r;
  assign load      = job_valid && (!valid_r || out_ready);
  assign pop       = load && (idx_r == last_idx);

  // number of items per job, minus one
  always_comb begin
    unique case (job.op)
      J_TIME:      last_idx = 5'd5;
      J_BUTTONS:   last_idx = 5'd3;
      J_ANALOG:    last_idx = 5'd16;
      J_BUSPARAM:  last_idx = 5'd11;
      J_DEVINFO:   last_idx = 5'd7;
      J_KEEPALIVE: last_idx = 5'd3;
      J_BUSCOUNT:  last_idx = 5'd2;
      J_EXTBUS:    last_idx = 5'd16;
      default:     last_idx = 5'd0;
    endcase
  end

  // reply byte at the current position
  always_comb begin
    rbyte = '0;
    if (idx_r == 5'd0) begin
      rbyte = SYNC_BYTE;
    end
    unique case (job.op)
      J_CONSOLE: rbyte = job.byte_val;
      J_TIME: begin
        unique case (idx_r)
          5'd0: rbyte = SYNC_BYTE;
          5'd1: rbyte = CMD_TIME_SYNC;
          5'd2: rbyte = job.word[7:0];
          5'd3: rbyte = job.word[15:8];
          5'd4: rbyte = job.word[23:16];
          default: rbyte = job.word[31:24];
        endcase
      end
      J_BUTTONS: begin
        unique case (idx_r)
          5'd0: rbyte = SYNC_BYTE;
          5'd1: rbyte = CMD_BUTTONS;
          5'd2: rbyte = job.byte_val;
          default: rbyte = SYNC_BYTE ^ CMD_BUTTONS ^ job.byte_val;
        endcase
      end
      J_ANALOG: begin
        if (idx_r == 5'd1) rbyte = CMD_ANALOG;
        else if (idx_r == 5'd16) rbyte = SYNC_BYTE ^ CMD_ANALOG;
      end
      J_BUSPARAM: begin
        unique case (idx_r)
          5'd0: rbyte = SYNC_BYTE;
          5'd1: rbyte = CMD_BUS_PARAM;
          5'd2: rbyte = {3'b0, listen_only, 3'b0, job.en};
          5'd3: rbyte = job.word[7:0];
          5'd4: rbyte = job.word[15:8];
          5'd5: rbyte = job.word[23:16];
          5'd6: rbyte = job.word[31:24];
          default: rbyte = '0;
        endcase
      end
      J_DEVINFO: begin
        unique case (idx_r)
          5'd0: rbyte = SYNC_BYTE;
          5'd1: rbyte = CMD_DEV_INFO;
          5'd2: rbyte = build_number[7:0];
          5'd3: rbyte = build_number[15:8];
          5'd4: rbyte = DEVINFO_BYTE;
          default: rbyte = '0;
        endcase
      end
      J_KEEPALIVE: begin
        unique case (idx_r)
          5'd0: rbyte = SYNC_BYTE;
          5'd1: rbyte = CMD_KEEPALIVE;
          5'd2: rbyte = KEEP_HI_BYTE;
          default: rbyte = KEEP_LO_BYTE;
        endcase
      end
      J_BUSCOUNT: begin
        if (idx_r == 5'd1) rbyte = CMD_BUS_COUNT;
        else if (idx_r == 5'd2) rbyte = 8'd1;
      end
      J_EXTBUS: begin
        if (idx_r == 5'd1) rbyte = CMD_EXT_BUSES;
      end
      default: rbyte = '0;
    endcase
  end

  // result item assembly
  always_comb begin
    res_nxt      = '0;
    res_nxt.last = (idx_r == last_idx);
    unique case (job.op)
      J_CONSOLE: begin res_nxt.kind = KIND_CONSOLE; res_nxt.byte_value = rbyte; end
      J_BINMODE: res_nxt.kind = KIND_BINMODE;
      J_SEND, J_ECHO: begin
        res_nxt.kind           = (job.op == J_SEND) ? KIND_SEND : KIND_ECHO;
        res_nxt.frame_id       = job.id;
        res_nxt.frame_extended = job.ext;
        res_nxt.frame_bus      = job.bus;
        res_nxt.frame_length   = job.len;
        res_nxt.frame_data     = job.data;
      end
      J_SAVE: begin
        res_nxt.kind            = KIND_SAVED;
        res_nxt.bus_enabled_out = job.en;
        res_nxt.bus_speed_out   = job.word[19:0];
        res_nxt.system_type_out = job.systype;
      end
      default: begin res_nxt.kind = KIND_REPLY; res_nxt.byte_value = rbyte; end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  // item counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= pop ? '0 : idx_r + 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end
endmodule

FILE: hdl/can_host_serial_command_parser_top.sv
// channel  | direction | tdata / tuser / tlast
// in_      | slave     | tdata: rx_byte, time_us, log_pressed, replay_pressed
// out_     | master    | tdata: result fields, tuser: kind, tlast: last
// cfg_     | apb slave | 0x0 listen_only, 0x4 build_number
//
// one host byte is taken per cycle while the job queue has room
// each byte yields at most one job; the reply generator drains one
// result item per cycle while out_tready is high; a job yields 1 to 17 items
// rst_n is synchronous; settings return to their power-up values
// a stalled output holds its register and, once the queue fills, stalls input
module can_host_serial_command_parser_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [7:0] rx_byte, [39:8] time_us, [40] log_pressed, [41] replay_pressed
  input  logic [47:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [7:0] byte_value, [38:8] frame_id, [39] frame_extended, [41:40] frame_bus,
  // [45:42] frame_length, [109:46] frame_data, [110] bus_enabled_out,
  // [130:111] bus_speed_out, [138:131] system_type_out
  output logic [143:0] out_tdata,
  // [2:0] kind
  output logic [2:0]   out_tuser,
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import cshp_pkg::*;

  logic        listen_only_r;
  logic [15:0] build_number_r;
  logic        cfg_wr;
  logic        push, pop, q_full, q_valid, in_fire;
  job_t        job_in, job_out;
  res_t        res;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = cfg_paddr[2] ? {16'b0, build_number_r} : {31'b0, listen_only_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      listen_only_r  <= 1'b0;
      build_number_r <= '0;
    end else if (cfg_wr) begin
      if (cfg_paddr[2]) build_number_r <= cfg_pwdata[15:0];
      else              listen_only_r  <= cfg_pwdata[0];
    end
  end

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid & in_tready;

  cshp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_fire        (in_fire),
    .rx_byte        (in_tdata[7:0]),
    .time_us        (in_tdata[39:8]),
    .log_pressed    (in_tdata[40]),
    .replay_pressed (in_tdata[41]),
    .push           (push),
    .job            (job_in)
  );

  cshp_queue #(
    .WIDTH ($bits(job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wdata     (job_in),
    .pop       (pop),
    .rdata     (job_out),
    .full      (q_full),
    .not_empty (q_valid)
  );

  cshp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .job          (job_out),
    .job_valid    (q_valid),
    .pop          (pop),
    .listen_only  (listen_only_r),
    .build_number (build_number_r),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .res          (res)
  );

  // result packing
  assign out_tuser = res.kind;
  assign out_tlast = res.last;
  assign out_tdata = {5'b0, res.system_type_out, res.bus_speed_out, res.bus_enabled_out,
                      res.frame_data, res.frame_length, res.frame_bus, res.frame_extended,
                      res.frame_id, res.byte_value};
endmodule
